/* rtl/core/ple_pkg.sv */
// ple_pkg: shared constants and types for the positional list engine.
// No dependencies.
`default_nettype none
package ple_pkg;
  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_BACK  = 3'd3,
    ACT_INS_AT    = 3'd4,
    ACT_DEL_AT    = 3'd5,
    ACT_DUMP      = 3'd6,
    ACT_NOP       = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // memory access request from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [IdxW-1:0]   rd_addr;
    logic              wr_en;
    logic [IdxW-1:0]   wr_addr;
    logic [31:0]       wr_data;
  } mem_req_t;
endpackage
`default_nettype wire

/* rtl/core/ple_ram.sv */
// ple_ram: entry storage, one write port and one registered read port.
// Depends on ple_pkg.
`default_nettype none
module ple_ram (
  input  wire logic              clk_i,
  input  wire ple_pkg::mem_req_t req_i,
  output logic [31:0]            rd_data_o
);
  logic [31:0] mem_q [ple_pkg::Capacity];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) mem_q[req_i.wr_addr] <= req_i.wr_data;
    if (req_i.rd_en) rd_data_o <= mem_q[req_i.rd_addr];
  end
endmodule
`default_nettype wire

/* rtl/core/positional_list_engine.sv */
// positional_list_engine: top level, sequencer around the entry RAM.
// Depends on ple_pkg and ple_ram.
//
//  channel | signals                                   | dir
//  in      | in_valid_i/in_ready_o, action/value/position | in
//  out     | out_valid_o/out_ready_i, status/count/element/element_valid/last | out
//
// One word at a time. Back inserts and back deletes move no entries; every other
// edit moves the entries after its position one at a time, each read and then written
// through the single RAM port pair. A dump reads each element and outputs it as its own word.
// Reset clears the count; entries stay undefined. A stalled output holds the
// sequencer; input is taken only when idle.
`default_nettype none
module positional_list_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [7:0]  position_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [4:0]       count_o,
  output logic signed [31:0] element_o,
  output logic             element_valid_o,
  output logic             last_o
);
  localparam int unsigned IdxW = ple_pkg::IdxW;
  localparam int unsigned CntW = ple_pkg::CntW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;  // read issued, data next cycle
  localparam logic [2:0] S_WR   = 3'd2;  // write shifted word
  localparam logic [2:0] S_DRD  = 3'd3;  // dump read wait
  localparam logic [2:0] S_OUT  = 3'd4;  // result waiting

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] ptr_q, ptr_d;     // current shift / dump index
  logic [CntW-1:0] tgt_q, tgt_d;     // target index of the edit
  logic            ins_q, ins_d;     // 1 insert shift, 0 delete shift
  logic            dump_q, dump_d;
  logic [31:0]     val_q, val_d;
  logic [1:0]      st_q, st_d;
  logic [31:0]     el_q, el_d;
  logic            ev_q, ev_d, last_q, last_d;
  ple_pkg::mem_req_t req;
  logic [31:0]     rd_data;

  ple_ram u_ram (.clk_i(clk_i), .req_i(req), .rd_data_o(rd_data));

  logic [8:0] pos9, cnt9;
  assign pos9 = {1'b0, position_i};
  assign cnt9 = 9'(cnt_q);

  // sequencer
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ptr_d = ptr_q; tgt_d = tgt_q;
    ins_d = ins_q; dump_d = dump_q; val_d = val_q; st_d = st_q;
    el_d = el_q; ev_d = ev_q; last_d = last_q;
    req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d = ple_pkg::ST_OK; el_d = '0; ev_d = 1'b0; last_d = 1'b1;
          val_d = value_i; dump_d = 1'b0; state_d = S_OUT;
          unique case (action_i) inside
            ple_pkg::ACT_INS_FRONT, ple_pkg::ACT_INS_BACK, ple_pkg::ACT_INS_AT: begin
              if (action_i == ple_pkg::ACT_INS_AT &&
                  (pos9 == 9'd0 || pos9 > cnt9 + 9'd1)) st_d = ple_pkg::ST_BADPOS;
              else if (cnt9 >= 9'(ple_pkg::Capacity)) st_d = ple_pkg::ST_FULL;
              else begin
                ins_d = 1'b1;
                tgt_d = (action_i == ple_pkg::ACT_INS_FRONT) ? '0 :
                        (action_i == ple_pkg::ACT_INS_BACK) ? cnt_q :
                        CntW'(pos9 - 9'd1);
                ptr_d = cnt_q;   // write index walks down from count
                state_d = S_RD;
              end
            end
            ple_pkg::ACT_DEL_FRONT, ple_pkg::ACT_DEL_BACK, ple_pkg::ACT_DEL_AT: begin
              if (action_i == ple_pkg::ACT_DEL_AT) begin
                if (pos9 == 9'd0 || pos9 > cnt9) st_d = ple_pkg::ST_BADPOS;
              end else if (cnt_q == '0) st_d = ple_pkg::ST_EMPTY;
              if (st_d == ple_pkg::ST_OK) begin
                ins_d = 1'b0;
                tgt_d = (action_i == ple_pkg::ACT_DEL_FRONT) ? '0 :
                        (action_i == ple_pkg::ACT_DEL_BACK) ? cnt_q - 1'b1 :
                        CntW'(pos9 - 9'd1);
                ptr_d = tgt_d;   // write index walks up
                state_d = S_RD;
              end
            end
            ple_pkg::ACT_DUMP: begin
              if (cnt_q != '0) begin
                dump_d = 1'b1; ptr_d = '0;
                req.rd_en = 1'b1; req.rd_addr = '0;
                state_d = S_DRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        // insert: move entry ptr-1 to ptr until ptr == tgt, then write value
        // delete: move entry ptr+1 to ptr until ptr+1 == count
        if (ins_q) begin
          if (ptr_q == tgt_q) begin
            req.wr_en = 1'b1; req.wr_addr = IdxW'(ptr_q); req.wr_data = val_q;
            cnt_d = cnt_q + 1'b1; state_d = S_OUT;
          end else begin
            req.rd_en = 1'b1; req.rd_addr = IdxW'(ptr_q - 1'b1);
            state_d = S_WR;
          end
        end else begin
          if (ptr_q + 1'b1 >= cnt_q) begin
            cnt_d = cnt_q - 1'b1; state_d = S_OUT;
          end else begin
            req.rd_en = 1'b1; req.rd_addr = IdxW'(ptr_q + 1'b1);
            state_d = S_WR;
          end
        end
      end
      S_WR: begin
        req.wr_en = 1'b1; req.wr_addr = IdxW'(ptr_q); req.wr_data = rd_data;
        ptr_d = ins_q ? ptr_q - 1'b1 : ptr_q + 1'b1;
        state_d = S_RD;
      end
      S_DRD: begin
        el_d = rd_data; ev_d = 1'b1; st_d = ple_pkg::ST_OK;
        last_d = (ptr_q + 1'b1 == cnt_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (dump_q && !last_q) begin
            ptr_d = ptr_q + 1'b1;
            req.rd_en = 1'b1; req.rd_addr = IdxW'(ptr_q + 1'b1);
            state_d = S_DRD;
          end else state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; dump_q <= 1'b0; ins_q <= 1'b0;
      ptr_q <= '0; tgt_q <= '0; last_q <= 1'b1;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; dump_q <= dump_d; ins_q <= ins_d;
      ptr_q <= ptr_d; tgt_q <= tgt_d; last_q <= last_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    val_q <= val_d; st_q <= st_d; el_q <= el_d; ev_q <= ev_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign status_o        = st_q;
  assign count_o         = 5'(cnt_q);
  assign element_o       = el_q;
  assign element_valid_o = ev_q;
  assign last_o          = last_q;
endmodule
`default_nettype wire

/* sim/tb.sv */
// tb: self-checking testbench for positional_list_engine.
// Depends on ple_pkg and the positional_list_engine RTL; drives a directed table
// then random list edits and dumps, checked against a behavioral list model.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  count;
    logic [31:0] element;
    logic        element_valid;
    logic        last;
  } result_t;

  typedef struct {
    ple_pkg::action_e act;
    logic [31:0] value;
    logic [7:0]  position;
    logic        known;      // expected result typed in below
    result_t     want;
  } row_t;

  localparam int NumRandom = 410;
  localparam int CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  action_i = '0;
  logic signed [31:0] value_i = '0;
  logic [7:0]  position_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [4:0]  count_o;
  logic signed [31:0] element_o;
  logic        element_valid_o;
  logic        last_o;

  // list model state
  logic [31:0] list_q[$];
  result_t     expected_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  positional_list_engine i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .value_i, .position_i,
    .out_valid_o, .out_ready_i, .status_o, .count_o, .element_o,
    .element_valid_o, .last_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic result_t edit_word(input ple_pkg::status_e st);
    result_t r;
    r = '{status: st, count: 5'(list_q.size()), element: '0, element_valid: 1'b0,
          last: 1'b1};
    return r;
  endfunction

  // apply one word to the list model and queue the words it produces
  task automatic predict_list_action(input ple_pkg::action_e act, input logic [31:0] v,
                                     input logic [7:0] p);
    ple_pkg::status_e st;
    int n;
    result_t r;
    st = ple_pkg::ST_OK;
    n = list_q.size();
    case (act) inside
      ple_pkg::ACT_INS_FRONT, ple_pkg::ACT_INS_BACK: begin
        if (n >= ple_pkg::Capacity) st = ple_pkg::ST_FULL;
        else if (act == ple_pkg::ACT_INS_FRONT) list_q.push_front(v);
        else list_q.push_back(v);
      end
      ple_pkg::ACT_DEL_FRONT, ple_pkg::ACT_DEL_BACK: begin
        if (n == 0) st = ple_pkg::ST_EMPTY;
        else if (act == ple_pkg::ACT_DEL_FRONT) void'(list_q.pop_front());
        else void'(list_q.pop_back());
      end
      ple_pkg::ACT_INS_AT: begin
        if (p < 1 || p > n + 1) st = ple_pkg::ST_BADPOS;
        else if (n >= ple_pkg::Capacity) st = ple_pkg::ST_FULL;
        else list_q.insert(p - 1, v);
      end
      ple_pkg::ACT_DEL_AT: begin
        if (p < 1 || p > n) st = ple_pkg::ST_BADPOS;
        else list_q.delete(p - 1);
      end
      ple_pkg::ACT_DUMP: begin
        if (n > 0) begin
          for (int i = 0; i < n; i++) begin
            r = '{status: ple_pkg::ST_OK, count: 5'(n), element: list_q[i],
                  element_valid: 1'b1, last: (i == n - 1)};
            expected_q.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    expected_q.push_back(edit_word(st));
  endtask

  // drive one word; valid stays up until accepted, the next call replaces it
  task automatic send_word(input ple_pkg::action_e act, input logic [31:0] v,
                           input logic [7:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    value_i <= v;
    position_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    predict_list_action(act, v, p);
    @(negedge clk_i);
  endtask

  // receiver ready, randomized per cycle unless held off
  always @(negedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // output checker
  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, count_o, element_o, element_valid_o, last_o};
      if (expected_q.size() == 0) report_mismatch($sformatf("unexpected word %p", got));
      else begin
        exp_r = expected_q.pop_front();
        if (got.status !== exp_r.status)
          report_mismatch($sformatf("status %0d exp %0d", got.status, exp_r.status));
        if (got.count !== exp_r.count)
          report_mismatch($sformatf("count %0d exp %0d", got.count, exp_r.count));
        if (got.element !== exp_r.element)
          report_mismatch($sformatf("element %0h exp %0h", got.element, exp_r.element));
        if (got.element_valid !== exp_r.element_valid)
          report_mismatch($sformatf("element_valid %0b exp %0b", got.element_valid,
                                    exp_r.element_valid));
        if (got.last !== exp_r.last)
          report_mismatch($sformatf("last %0b exp %0b", got.last, exp_r.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic ple_pkg::action_e rand_action();
    int n;
    int k;
    n = list_q.size();
    k = $urandom_range(99);
    // lean toward growth when short, shrink once 12 or more entries are held
    if (k < 30) return (n < 12) ? ple_pkg::ACT_INS_BACK : ple_pkg::ACT_DEL_FRONT;
    if (k < 40) return ple_pkg::ACT_INS_FRONT;
    if (k < 50) return ple_pkg::ACT_DEL_BACK;
    if (k < 65) return ple_pkg::ACT_INS_AT;
    if (k < 78) return ple_pkg::ACT_DEL_AT;
    if (k < 90) return ple_pkg::ACT_DUMP;
    if (k < 95) return ple_pkg::ACT_DEL_FRONT;
    return ple_pkg::ACT_NOP;
  endfunction

  function automatic logic [7:0] rand_position();
    int n;
    n = list_q.size();
    if ($urandom_range(9) < 8) return 8'($urandom_range(n + 1));
    return 8'($urandom_range(255));
  endfunction

  row_t directed[$];

  initial begin
    result_t want;
    int phase;
    directed = '{
      '{ple_pkg::ACT_DUMP, 32'd0, 8'd0, 1'b1,
        '{ple_pkg::ST_OK, 5'd0, 32'd0, 1'b0, 1'b1}},
      '{ple_pkg::ACT_DEL_FRONT, 32'd0, 8'd0, 1'b1,
        '{ple_pkg::ST_EMPTY, 5'd0, 32'd0, 1'b0, 1'b1}},
      '{ple_pkg::ACT_DEL_BACK, 32'd0, 8'd0, 1'b1,
        '{ple_pkg::ST_EMPTY, 5'd0, 32'd0, 1'b0, 1'b1}},
      '{ple_pkg::ACT_DEL_AT, 32'd0, 8'd1, 1'b1,
        '{ple_pkg::ST_BADPOS, 5'd0, 32'd0, 1'b0, 1'b1}},
      '{ple_pkg::ACT_INS_AT, 32'd0, 8'd0, 1'b1,
        '{ple_pkg::ST_BADPOS, 5'd0, 32'd0, 1'b0, 1'b1}},
      '{ple_pkg::ACT_INS_AT, 32'd0, 8'd2, 1'b1,
        '{ple_pkg::ST_BADPOS, 5'd0, 32'd0, 1'b0, 1'b1}},
      '{ple_pkg::ACT_NOP, 32'hffff_ffff, 8'hff, 1'b1,
        '{ple_pkg::ST_OK, 5'd0, 32'd0, 1'b0, 1'b1}},
      '{ple_pkg::ACT_INS_FRONT, 32'h8000_0000, 8'd0, 1'b1,
        '{ple_pkg::ST_OK, 5'd1, 32'd0, 1'b0, 1'b1}},
      '{ple_pkg::ACT_INS_BACK, 32'h7fff_ffff, 8'd0, 1'b1,
        '{ple_pkg::ST_OK, 5'd2, 32'd0, 1'b0, 1'b1}},
      '{ple_pkg::ACT_INS_AT, 32'hffff_ffff, 8'd3, 1'b0, '0},
      '{ple_pkg::ACT_INS_AT, 32'h0, 8'd1, 1'b0, '0},
      '{ple_pkg::ACT_INS_AT, 32'h5555_aaaa, 8'd2, 1'b0, '0},
      '{ple_pkg::ACT_DUMP, 32'd0, 8'd0, 1'b0, '0},
      '{ple_pkg::ACT_DEL_AT, 32'd0, 8'd0, 1'b0, '0},
      '{ple_pkg::ACT_DEL_AT, 32'd0, 8'd6, 1'b0, '0},
      '{ple_pkg::ACT_DEL_AT, 32'd0, 8'd2, 1'b0, '0},
      '{ple_pkg::ACT_DEL_AT, 32'd0, 8'd4, 1'b0, '0},
      '{ple_pkg::ACT_DEL_FRONT, 32'd0, 8'd0, 1'b0, '0},
      '{ple_pkg::ACT_DEL_BACK, 32'd0, 8'd0, 1'b0, '0},
      '{ple_pkg::ACT_DUMP, 32'd0, 8'd0, 1'b0, '0}
    };
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (directed[i]) begin
      send_word(directed[i].act, directed[i].value, directed[i].position);
      if (directed[i].known) begin
        want = expected_q[$];
        if (want !== directed[i].want)
          report_mismatch($sformatf("row %0d model disagrees with table", i));
      end
    end
    // fill to capacity, then full-list cases
    while (list_q.size() < ple_pkg::Capacity)
      send_word(ple_pkg::ACT_INS_BACK, $urandom(), 8'd0);
    send_word(ple_pkg::ACT_INS_FRONT, 32'd1, 8'd0);
    send_word(ple_pkg::ACT_INS_BACK, 32'd1, 8'd0);
    send_word(ple_pkg::ACT_INS_AT, 32'd1, 8'(ple_pkg::Capacity + 2));
    send_word(ple_pkg::ACT_INS_AT, 32'd1, 8'(ple_pkg::Capacity + 1));
    send_word(ple_pkg::ACT_DUMP, 32'd0, 8'd0);
    send_word(ple_pkg::ACT_DEL_AT, 32'd0, 8'(ple_pkg::Capacity));

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (6) send_word(ple_pkg::ACT_DUMP, 32'd0, 8'd0);
    join

    // random phases with varying idle profiles
    for (int n = 0; n < NumRandom; n++) begin
      phase = (n / 40) % 5;
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        3: begin send_idle_pct = 36; recv_stall_pct = 36; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      send_word(rand_action(), rand_value(), rand_position());
    end
    send_word(ple_pkg::ACT_DUMP, 32'd0, 8'd0);
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
